// ===== sv/dts_pkg.sv =====
package dts_pkg;

    typedef enum logic [1:0] {
        MODE_BEGIN = 2'd0,
        MODE_EDGE  = 2'd1,
        MODE_RUN   = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    localparam logic [1:0] MARK_NEW  = 2'd0;
    localparam logic [1:0] MARK_OPEN = 2'd1;
    localparam logic [1:0] MARK_DONE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR_G,
        ST_E_RD,
        ST_E_WR,
        ST_E_LINK,
        ST_R_CLR,
        ST_R_ROOT,
        ST_R_ROOTCHK,
        ST_R_NEXT,
        ST_R_STEP,
        ST_R_POP,
        ST_R_EDGE,
        ST_R_CHK,
        ST_O_INIT,
        ST_O_RD,
        ST_O_WAIT
    } state_t;

endpackage

// ===== sv/dts_vertex_mem.sv =====
module dts_vertex_mem
    import dts_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW = 6,
    parameter int PW = 11
) (
    input  logic          aclk,
    input  logic [AW-1:0] rd_addr,
    output logic [PW-1:0] rd_head,
    output logic [PW-1:0] rd_tail,
    output logic [1:0]    rd_mark,
    input  logic [AW-1:0] wr_addr,
    input  logic          wr_head_en,
    input  logic          wr_tail_en,
    input  logic          wr_mark_en,
    input  logic [PW-1:0] wr_head,
    input  logic [PW-1:0] wr_tail,
    input  logic [1:0]    wr_mark
);

    logic [PW-1:0] head_mem [DEPTH];
    logic [PW-1:0] tail_mem [DEPTH];
    logic [1:0]    mark_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_head_en) begin
            head_mem[wr_addr] <= wr_head;
        end
        if (wr_tail_en) begin
            tail_mem[wr_addr] <= wr_tail;
        end
        if (wr_mark_en) begin
            mark_mem[wr_addr] <= wr_mark;
        end
        rd_head <= head_mem[rd_addr];
        rd_tail <= tail_mem[rd_addr];
        rd_mark <= mark_mem[rd_addr];
    end

endmodule

// ===== sv/dts_edge_mem.sv =====
module dts_edge_mem
    import dts_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW = 10,
    parameter int VW = 6,
    parameter int PW = 11
) (
    input  logic          aclk,
    input  logic [AW-1:0] rd_addr,
    output logic [VW-1:0] rd_target,
    output logic [PW-1:0] rd_next,
    input  logic [AW-1:0] wr_addr,
    input  logic          wr_target_en,
    input  logic          wr_next_en,
    input  logic [VW-1:0] wr_target,
    input  logic [PW-1:0] wr_next
);

    logic [VW-1:0] target_mem [DEPTH];
    logic [PW-1:0] next_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_target_en) begin
            target_mem[wr_addr] <= wr_target;
        end
        if (wr_next_en) begin
            next_mem[wr_addr] <= wr_next;
        end
        rd_target <= target_mem[rd_addr];
        rd_next   <= next_mem[rd_addr];
    end

endmodule

// ===== sv/dfs_topological_sort_core.sv =====
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_mode, s_vertex_count, s_edge_from, s_edge_to
// m_        out        m_valid / m_ready  m_vertex, m_last, m_edges_dropped
//
// One request is taken at a time; s_ready is high only while the sequencer is idle.
// A begin request clears one list entry per cycle. A dropped edge is only recorded in the
// idle state; a stored edge passes ST_E_RD and ST_E_WR, and ST_E_LINK when the source list
// was not empty. A run clears the marks, searches from each unmarked root, then emits the
// results in reverse finish order. Each state makes at most one read and one write per memory.
// Reset (aresetn low) empties the graph; m_valid holds its result until m_ready.
module dfs_topological_sort_core
    import dts_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES = 1024
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [6:0] s_vertex_count,
    input  logic [6:0] s_edge_from,
    input  logic [6:0] s_edge_to,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_vertex,
    output logic       m_last,
    output logic       m_edges_dropped
);

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int PW  = $clog2(MAX_EDGES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

    state_t state_reg, state_next;

    logic [CW-1:0] active_reg;
    logic [PW-1:0] edge_total_reg;
    logic          drop_reg;
    logic [VW-1:0] idx_reg;
    logic [VW-1:0] root_reg;
    logic [VW-1:0] src_reg;
    logic [VW-1:0] tgt_reg;
    logic [PW-1:0] tail_reg;
    logic [VW-1:0] cur_v_reg;
    logic [PW-1:0] cur_p_reg;
    logic [CW-1:0] depth_reg;
    logic [CW-1:0] done_reg;
    logic [VW-1:0] emit_reg;
    logic [6:0]    m_vertex_reg;
    logic          m_last_reg;
    logic          m_drop_reg;
    logic          m_valid_reg;

    logic [VW-1:0] vm_rd_addr, vm_wr_addr;
    logic [PW-1:0] vm_rd_head, vm_rd_tail, vm_wr_head, vm_wr_tail;
    logic [1:0]    vm_rd_mark, vm_wr_mark;
    logic          vm_head_en, vm_tail_en, vm_mark_en;

    logic [EAW-1:0] em_rd_addr, em_wr_addr;
    logic [VW-1:0]  em_rd_target, em_wr_target;
    logic [PW-1:0]  em_rd_next, em_wr_next;
    logic           em_target_en, em_next_en;

    logic [VW+PW-1:0] walk_mem [MAX_VERTICES];
    logic [VW+PW-1:0] walk_rd;
    logic [VW-1:0]    fin_mem [MAX_VERTICES];
    logic [VW-1:0]    fin_rd;
    logic [VW-1:0]    fin_addr;

    logic          s_accept;
    logic          edge_bad;
    logic [CW-1:0] count_sat;
    logic          idx_last;
    logic          root_last;
    logic [PW-1:0] slot_p1;

    assign s_accept = s_valid && s_ready;
    assign count_sat = (32'(s_vertex_count) > MAX_VERTICES) ? CW'(MAX_VERTICES)
                                                            : CW'(s_vertex_count);
    assign edge_bad = (s_edge_from == 7'd0) || (32'(s_edge_from) > 32'(active_reg)) ||
                      (s_edge_to == 7'd0) || (32'(s_edge_to) > 32'(active_reg)) ||
                      (32'(edge_total_reg) >= MAX_EDGES);
    assign idx_last  = (CW'(idx_reg) + CW'(1)) == active_reg;
    assign root_last = (CW'(root_reg) + CW'(1)) == active_reg;
    assign slot_p1   = edge_total_reg + PW'(1);

    // The finish list is read one request ahead so that its data is ready in ST_O_RD.
    assign fin_addr = (state_reg == ST_O_INIT) ? VW'(done_reg - CW'(1)) :
                      (state_reg == ST_O_WAIT) ? emit_reg - VW'(1) : emit_reg;

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_vertex        = m_vertex_reg;
    assign m_last          = m_last_reg;
    assign m_edges_dropped = m_drop_reg;

    dts_vertex_mem #(
        .DEPTH(MAX_VERTICES), .AW(VW), .PW(PW)
    ) u_vertex_mem (
        .aclk(aclk),
        .rd_addr(vm_rd_addr), .rd_head(vm_rd_head), .rd_tail(vm_rd_tail),
        .rd_mark(vm_rd_mark),
        .wr_addr(vm_wr_addr), .wr_head_en(vm_head_en), .wr_tail_en(vm_tail_en),
        .wr_mark_en(vm_mark_en), .wr_head(vm_wr_head), .wr_tail(vm_wr_tail),
        .wr_mark(vm_wr_mark)
    );

    dts_edge_mem #(
        .DEPTH(MAX_EDGES), .AW(EAW), .VW(VW), .PW(PW)
    ) u_edge_mem (
        .aclk(aclk),
        .rd_addr(em_rd_addr), .rd_target(em_rd_target), .rd_next(em_rd_next),
        .wr_addr(em_wr_addr), .wr_target_en(em_target_en), .wr_next_en(em_next_en),
        .wr_target(em_wr_target), .wr_next(em_wr_next)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (s_mode)
                        MODE_BEGIN: begin
                            if (count_sat != '0) state_next = ST_CLR_G;
                        end
                        MODE_EDGE: begin
                            if (!edge_bad) state_next = ST_E_RD;
                        end
                        MODE_RUN: begin
                            if (active_reg != '0) state_next = ST_R_CLR;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLR_G:     if (idx_last) state_next = ST_IDLE;
            ST_E_RD:      state_next = ST_E_WR;
            ST_E_WR:      state_next = (vm_rd_tail == '0) ? ST_IDLE : ST_E_LINK;
            ST_E_LINK:    state_next = ST_IDLE;
            ST_R_CLR:     if (idx_last) state_next = ST_R_ROOT;
            ST_R_ROOT:    state_next = ST_R_ROOTCHK;
            ST_R_ROOTCHK: state_next = (vm_rd_mark == MARK_NEW) ? ST_R_STEP : ST_R_NEXT;
            ST_R_NEXT:    state_next = root_last ? ST_O_INIT : ST_R_ROOT;
            ST_R_STEP: begin
                if (cur_p_reg != '0) begin
                    state_next = ST_R_EDGE;
                end else if (depth_reg == CW'(1)) begin
                    state_next = ST_R_NEXT;
                end else begin
                    state_next = ST_R_POP;
                end
            end
            ST_R_POP:     state_next = ST_R_STEP;
            ST_R_EDGE:    state_next = ST_R_CHK;
            ST_R_CHK:     state_next = ST_R_STEP;
            ST_O_INIT:    state_next = ST_O_RD;
            ST_O_RD:      state_next = ST_O_WAIT;
            ST_O_WAIT: begin
                if (m_ready) state_next = m_last_reg ? ST_IDLE : ST_O_RD;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        vm_rd_addr   = '0;
        vm_wr_addr   = '0;
        vm_head_en   = 1'b0;
        vm_tail_en   = 1'b0;
        vm_mark_en   = 1'b0;
        vm_wr_head   = '0;
        vm_wr_tail   = '0;
        vm_wr_mark   = MARK_NEW;
        em_rd_addr   = '0;
        em_wr_addr   = '0;
        em_target_en = 1'b0;
        em_next_en   = 1'b0;
        em_wr_target = tgt_reg;
        em_wr_next   = '0;
        case (state_reg)
            ST_CLR_G: begin
                vm_wr_addr = idx_reg;
                vm_head_en = 1'b1;
                vm_tail_en = 1'b1;
            end
            ST_E_RD: vm_rd_addr = src_reg;
            ST_E_WR: begin
                em_wr_addr   = EAW'(edge_total_reg);
                em_target_en = 1'b1;
                em_next_en   = 1'b1;
                vm_wr_addr   = src_reg;
                vm_tail_en   = 1'b1;
                vm_wr_tail   = slot_p1;
                vm_head_en   = (vm_rd_tail == '0);
                vm_wr_head   = slot_p1;
            end
            ST_E_LINK: begin
                em_wr_addr = EAW'(tail_reg - PW'(1));
                em_next_en = 1'b1;
                em_wr_next = edge_total_reg;
            end
            ST_R_CLR: begin
                vm_wr_addr = idx_reg;
                vm_mark_en = 1'b1;
            end
            ST_R_ROOT: vm_rd_addr = root_reg;
            ST_R_ROOTCHK: begin
                vm_wr_addr = root_reg;
                vm_mark_en = (vm_rd_mark == MARK_NEW);
                vm_wr_mark = MARK_OPEN;
            end
            ST_R_STEP: begin
                em_rd_addr = EAW'(cur_p_reg - PW'(1));
                vm_wr_addr = cur_v_reg;
                vm_mark_en = (cur_p_reg == '0);
                vm_wr_mark = MARK_DONE;
            end
            ST_R_EDGE: vm_rd_addr = em_rd_target;
            ST_R_CHK: begin
                vm_wr_addr = tgt_reg;
                vm_mark_en = (vm_rd_mark == MARK_NEW);
                vm_wr_mark = MARK_OPEN;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_R_CHK && vm_rd_mark == MARK_NEW) begin
            walk_mem[VW'(depth_reg - CW'(1))] <= {cur_v_reg, cur_p_reg};
        end
        walk_rd <= walk_mem[VW'(depth_reg - CW'(2))];
        if (state_reg == ST_R_STEP && cur_p_reg == '0) begin
            fin_mem[VW'(done_reg)] <= cur_v_reg;
        end
        fin_rd <= fin_mem[fin_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            active_reg     <= '0;
            edge_total_reg <= '0;
            drop_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    idx_reg  <= '0;
                    root_reg <= '0;
                    done_reg <= '0;
                    src_reg  <= VW'(s_edge_from - 7'd1);
                    tgt_reg  <= VW'(s_edge_to - 7'd1);
                    if (s_accept && s_mode == MODE_BEGIN) begin
                        active_reg     <= count_sat;
                        edge_total_reg <= '0;
                        drop_reg       <= 1'b0;
                    end
                    if (s_accept && s_mode == MODE_EDGE && edge_bad) begin
                        drop_reg <= 1'b1;
                    end
                end
                ST_CLR_G, ST_R_CLR: idx_reg <= idx_reg + VW'(1);
                ST_E_WR: begin
                    tail_reg       <= vm_rd_tail;
                    edge_total_reg <= slot_p1;
                end
                ST_R_ROOTCHK: begin
                    cur_v_reg <= root_reg;
                    cur_p_reg <= vm_rd_head;
                    depth_reg <= CW'(1);
                end
                ST_R_NEXT: root_reg <= root_reg + VW'(1);
                ST_R_STEP: begin
                    if (cur_p_reg == '0) begin
                        done_reg  <= done_reg + CW'(1);
                        depth_reg <= depth_reg - CW'(1);
                    end
                end
                ST_R_POP: {cur_v_reg, cur_p_reg} <= walk_rd;
                ST_R_EDGE: begin
                    cur_p_reg <= em_rd_next;
                    tgt_reg   <= em_rd_target;
                end
                ST_R_CHK: begin
                    if (vm_rd_mark == MARK_NEW) begin
                        cur_v_reg <= tgt_reg;
                        cur_p_reg <= vm_rd_head;
                        depth_reg <= depth_reg + CW'(1);
                    end
                end
                ST_O_INIT: emit_reg <= VW'(done_reg - CW'(1));
                ST_O_RD: begin
                    m_vertex_reg <= 7'(32'(fin_rd) + 1);
                    m_last_reg   <= (emit_reg == '0);
                    m_drop_reg   <= drop_reg;
                    m_valid_reg  <= 1'b1;
                end
                ST_O_WAIT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        emit_reg    <= emit_reg - VW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
